// File: rtl/core/hss_pkg.sv
// hss_pkg: types and fixed constants of the harmonic sine synthesiser
// no dependencies; imported by the top level, the sine rom and the checker
package hss_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SLOT_W     = 4;
  localparam int STEP_W     = 32;
  localparam int AMP_W      = 15;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 24;
  localparam int SAMPLE_W   = 21;
  localparam int SINE_W     = 15;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 24;
  localparam int EXT_W      = 48;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_AMP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARM_COUNT = 4'd1;

  localparam logic [AMP_W-1:0] BASE_AMP_RESET = 15'd32767;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int SAMPLE_MAX = 1048575;
  localparam int SAMPLE_MIN = -1048576;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_AMP,
    ST_LOOKUP,
    ST_MUL_SINE,
    ST_ACCUM,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/hss_ram.sv
// hss_ram: generic single write port, single read port ram, registered read
// no dependencies
module hss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/hss_sine_rom.sv
// hss_sine_rom: quarter-wave sine rom, built at elaboration, registered read
// depends on hss_pkg
module hss_sine_rom
  import hss_pkg::*;
#(
  parameter int TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [TABLE_BITS:0] addr,
  output logic [SINE_W-1:0]   rdata
);

  localparam int QSIZE = 1 << TABLE_BITS;

  typedef logic [SINE_W-1:0] rom_t [QSIZE+1];

  function automatic rom_t build_rom();
    rom_t               t;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] acc;
    int                 n;
    for (int k = 0; k <= QSIZE; k++) begin
      x = (HALF_PI_Q30 * 64'(k) + 64'(QSIZE / 2)) >> TABLE_BITS;
      acc = $signed(x);
      term = x;
      for (n = 1; n < 16 && term != 64'd0; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = 64'sd0;
      end
      mag = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      t[k] = SINE_W'(mag);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [SINE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= ROM[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/harmonic_sine_synth_top.sv
// harmonic_sine_synth_top: additive sine synthesiser with a shared multiplier
// depends on hss_pkg, hss_ram and hss_sine_rom
//
// A load transaction (in_cmd = 0) writes one harmonic slot in the cycle it is
// accepted and busy stays low. A sample transaction (in_cmd = 1) holds busy
// through N harmonic passes and a done state, N = min(harmonic_count,
// MAX_HARMONICS); the result shows on out_sample with out_valid high for one
// cycle as busy drops; the receiver cannot stall it. Each harmonic runs
// MUL_LO, MUL_HI, MUL_AMP, LOOKUP, MUL_SINE, ACCUM: one 32x24 multiplier is
// used four times per harmonic (two phase partial products, base times
// harmonic amplitude, amplitude times sine) around one registered sine rom
// lookup and one accumulate. A new transaction may be accepted in the cycle
// the result strobe shows. Configuration writes are always taken.
module harmonic_sine_synth_top
  import hss_pkg::*;
#(
  parameter int MAX_HARMONICS   = 16,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic [SLOT_W-1:0]          in_slot,
  input  logic [STEP_W-1:0]          in_phase_step,
  input  logic [STEP_W-1:0]          in_start_phase,
  input  logic [AMP_W-1:0]           in_harmonic_amplitude,
  input  logic [INDEX_W-1:0]         in_sample_index,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW       = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int CNT_W    = $clog2(MAX_HARMONICS + 1);
  localparam int ENT_W    = AMP_W + 2 * STEP_W;
  localparam int WIDE_W   = STEP_W + EXT_W;
  localparam int LB       = PHASE_BITS - 2;
  localparam int QSHIFT   = LB - SINE_TABLE_BITS;
  localparam int SUM_RAW  = 17 + $clog2(MAX_HARMONICS + 1);
  localparam int SUM_W    = (SUM_RAW > 22) ? SUM_RAW : 22;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  localparam logic [LB:0]               RND    = (LB + 1)'((48'd1 << QSHIFT) >> 1);
  localparam logic [SINE_TABLE_BITS:0]  QSIZE  = (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS);
  localparam logic [7:0]                MAX_V  = 8'(MAX_HARMONICS);
  localparam logic signed [SUM_W-1:0]   SAT_HI = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0]   SAT_LO = SUM_W'(SAMPLE_MIN);

  state_t state_r, state_nxt;

  logic [AMP_W-1:0]          base_r;
  logic [COUNT_W-1:0]        harm_count_r;
  logic [MAX_HARMONICS-1:0]  slot_valid_r;
  logic [CNT_W-1:0]          hidx_r, hidx_nxt;
  logic [CNT_W-1:0]          limit_r, limit_nxt;
  logic [INDEX_W-1:0]        n_r, n_nxt;
  logic                      ent_valid_r;
  logic [PROD_W-1:0]         prod_r;
  logic [EXT_W-1:0]          phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0]     phase_r, phase_nxt;
  logic [2*AMP_W-1:0]        amp_r, amp_nxt;
  logic                      sine_neg_r, sine_neg_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic                      accept;
  logic                      accept_load;
  logic                      accept_sample;
  logic                      last_harm;
  logic [7:0]                lim8;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ENT_W-1:0]          ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [ENT_W-1:0]          ram_rdata;
  logic [STEP_W-1:0]         ent_step;
  logic [STEP_W-1:0]         ent_start;
  logic [AMP_W-1:0]          ent_amp;
  logic [EXT_W-1:0]          step_ext;
  logic [EXT_W-1:0]          start_ext;
  logic                      rom_re;
  logic [SINE_TABLE_BITS:0]  rom_addr;
  logic [SINE_W-1:0]         rom_data;
  logic [LB:0]               idx_full;
  logic [SINE_TABLE_BITS:0]  idx;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod_nxt;
  logic [15:0]               term_mag;
  logic signed [SUM_W-1:0]   term_s;

  assign accept        = start && !busy;
  assign accept_load   = accept && (in_cmd == CMD_LOAD);
  assign accept_sample = accept && (in_cmd == CMD_SAMPLE);
  assign last_harm     = (hidx_r + CNT_W'(1)) == limit_r;
  assign lim8          = (8'(harm_count_r) > MAX_V) ? MAX_V : 8'(harm_count_r);

  assign ram_we    = accept_load && (8'(in_slot) < MAX_V);
  assign ram_waddr = AW'(in_slot);
  assign ram_wdata = {in_harmonic_amplitude, in_start_phase, in_phase_step};
  assign ram_raddr = AW'(hidx_nxt);

  hss_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_HARMONICS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hss_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk   (clk),
    .rd_en (rom_re),
    .addr  (rom_addr),
    .rdata (rom_data)
  );

  // never-written slots read as zero
  assign ent_step  = ent_valid_r ? ram_rdata[STEP_W-1:0] : '0;
  assign ent_start = ent_valid_r ? ram_rdata[2*STEP_W-1:STEP_W] : '0;
  assign ent_amp   = ent_valid_r ? ram_rdata[ENT_W-1:2*STEP_W] : '0;

  // align q0.32 to the phase width
  assign step_ext  = EXT_W'({ent_step, {EXT_W{1'b0}}} >> (WIDE_W - PHASE_BITS));
  assign start_ext = EXT_W'({ent_start, {EXT_W{1'b0}}} >> (WIDE_W - PHASE_BITS));

  // quarter-wave index, round half up, mirrored in odd quadrants
  assign idx_full = ((LB + 1)'(phase_r[LB-1:0]) + RND) >> QSHIFT;
  assign idx      = (SINE_TABLE_BITS + 1)'(idx_full);
  assign rom_addr = phase_r[LB] ? (QSIZE - idx) : idx;

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign term_mag = 16'((prod_r[45:0] + 46'd536870912) >> 30);
  assign term_s   = $signed(SUM_W'(term_mag));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_sample) begin
          state_nxt = (lim8 == 8'd0) ? ST_DONE : ST_MUL_LO;
        end
      end
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_MUL_AMP;
      ST_MUL_AMP:  state_nxt = ST_LOOKUP;
      ST_LOOKUP:   state_nxt = ST_MUL_SINE;
      ST_MUL_SINE: state_nxt = ST_ACCUM;
      ST_ACCUM:    state_nxt = last_harm ? ST_DONE : ST_MUL_LO;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    ram_re = 1'b0;
    rom_re = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        ram_re = accept_sample;
      end
      ST_MUL_LO: begin
        mul_a = MUL_A_W'(step_ext[23:0]);
        mul_b = n_r;
      end
      ST_MUL_HI: begin
        mul_a = MUL_A_W'(step_ext[EXT_W-1:24]);
        mul_b = n_r;
      end
      ST_MUL_AMP: begin
        mul_a = MUL_A_W'(base_r);
        mul_b = MUL_B_W'(ent_amp);
      end
      ST_LOOKUP: begin
        rom_re = 1'b1;
      end
      ST_MUL_SINE: begin
        mul_a = MUL_A_W'(amp_r);
        mul_b = MUL_B_W'(rom_data);
      end
      ST_ACCUM: begin
        ram_re = !last_harm;
      end
      ST_DONE: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    hidx_nxt       = hidx_r;
    limit_nxt      = limit_r;
    n_nxt          = n_r;
    phase_acc_nxt  = phase_acc_r;
    phase_nxt      = phase_r;
    amp_nxt        = amp_r;
    sine_neg_nxt   = sine_neg_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = 1'b0;
    out_sample_nxt = out_sample_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_sample) begin
          hidx_nxt  = '0;
          limit_nxt = CNT_W'(lim8);
          n_nxt     = in_sample_index;
          sum_nxt   = '0;
        end
      end
      ST_MUL_HI: begin
        phase_acc_nxt = start_ext + prod_r[EXT_W-1:0];
      end
      ST_MUL_AMP: begin
        phase_nxt = PHASE_BITS'(phase_acc_r + {prod_r[23:0], 24'd0});
      end
      ST_LOOKUP: begin
        amp_nxt      = prod_r[2*AMP_W-1:0];
        sine_neg_nxt = phase_r[PHASE_BITS-1];
      end
      ST_ACCUM: begin
        sum_nxt  = sine_neg_r ? (sum_r - term_s) : (sum_r + term_s);
        hidx_nxt = hidx_r + CNT_W'(1);
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        if (sum_r > SAT_HI) begin
          out_sample_nxt = SAMPLE_W'(SAT_HI);
        end else if (sum_r < SAT_LO) begin
          out_sample_nxt = SAMPLE_W'(SAT_LO);
        end else begin
          out_sample_nxt = sum_r[SAMPLE_W-1:0];
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= BASE_AMP_RESET;
      harm_count_r <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BASE_AMP) begin
          base_r <= cfg_data[AMP_W-1:0];
        end else if (cfg_index == REG_HARM_COUNT) begin
          harm_count_r <= cfg_data[COUNT_W-1:0];
        end
      end
      if (ram_we) begin
        slot_valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hidx_r       <= hidx_nxt;
    limit_r      <= limit_nxt;
    n_r          <= n_nxt;
    prod_r       <= prod_nxt;
    phase_acc_r  <= phase_acc_nxt;
    phase_r      <= phase_nxt;
    amp_r        <= amp_nxt;
    sine_neg_r   <= sine_neg_nxt;
    sum_r        <= sum_nxt;
    out_sample_r <= out_sample_nxt;
    if (ram_re) begin
      ent_valid_r <= slot_valid_r[ram_raddr];
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// File: rtl/core/hss_checker.sv
// hss_checker: port-level checks of the harmonic sine synthesiser
// depends on hss_pkg; bound to harmonic_sine_synth_top
module hss_checker
  import hss_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic signed [SAMPLE_W-1:0] out_sample
);

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // load transaction completes at once
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> !busy)
    else $error("load transaction raised busy");

  // sample transaction occupies the block
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_SAMPLE) |=> busy)
    else $error("sample transaction did not raise busy");

  // result ends a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of busy period");

  // a sample is known when shown
  a_sample_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_sample))
    else $error("result sample unknown");

endmodule

bind harmonic_sine_synth_top hss_checker u_checker (.*);
